### design/spr_pkg.sv
// ----------------------------------------------------------------------------
// spr_pkg
// Shared types and constants for the step-pulse ramp generator.
// ----------------------------------------------------------------------------
`default_nettype none

package spr_pkg;

    localparam int POSITION_BITS = 32;
    localparam int PERIOD_BITS   = 8;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 32;

    localparam logic [PERIOD_BITS-1:0] IDLE_PERIOD = 8'd255;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_START = 2'd1,
        OP_STOP  = 2'd2,
        OP_LOAD  = 2'd3
    } opcode_t;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_START_PERIOD   = 3'd0,
        REG_TARGET_PERIOD  = 3'd1,
        REG_FINAL_POSITION = 3'd2,
        REG_REVERSE        = 3'd3,
        REG_RAMP_ENABLE    = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic [PERIOD_BITS-1:0]   start_period;
        logic [PERIOD_BITS-1:0]   target_period;
        logic [POSITION_BITS-1:0] final_position;
        logic                     reverse;
        logic                     ramp_enable;
    } cfg_t;

    typedef struct packed {
        logic                     step_level;
        logic                     output_enabled;
        logic [POSITION_BITS-1:0] position;
        logic [PERIOD_BITS-1:0]   period;
        logic                     run_finished;
    } result_t;

endpackage

`default_nettype wire

### design/stepper_pulse_ramp_generator_top.sv
// ----------------------------------------------------------------------------
// stepper_pulse_ramp_generator_top
// Step-pulse generator with trapezoidal period ramp for a stepper motor.
// ----------------------------------------------------------------------------
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------------------------
//  in       | in_valid / in_stall  | opcode, position_value
//  out      | out_valid / out_stall| step_level, output_enabled, position_now,
//           |                      | period_now, run_finished
//  cfg      | cfg_wr_en            | cfg_index, cfg_data
//
//  One request per cycle while the output is not stalled; a request taken into
//  the input register moves into the result register once that is free or drained.
//  The core update (counter compare, position step, ramp compares) is the
//  single combinational pass between the input and result registers.
//  Reset loads the configuration and state defaults; no clearing pass.
//  A stalled result holds; the input register keeps taking requests
//  while the result register is free or being drained.
// ----------------------------------------------------------------------------
`default_nettype none

module stepper_pulse_ramp_generator_top
    import spr_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_stall,
    input  wire logic [1:0]               opcode,
    input  wire logic signed [31:0]       position_value,
    output logic                          out_valid,
    input  wire logic                     out_stall,
    output logic                          step_level,
    output logic                          output_enabled,
    output logic signed [31:0]            position_now,
    output logic [7:0]                    period_now,
    output logic                          run_finished,
    input  wire logic                     cfg_wr_en,
    input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0] cfg_data
);

    cfg_t    cfg;
    result_t core_result;
    result_t result_reg;

    logic                     in_valid_reg, in_valid_next;
    logic [1:0]               opcode_reg;
    logic [POSITION_BITS-1:0] pos_value_reg;
    logic                     out_valid_reg, out_valid_next;
    logic                     fire;
    logic                     in_accept;

    assign fire      = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = in_valid_reg && !fire;
    assign in_accept = in_valid && !in_stall;

    assign in_valid_next  = in_accept ? 1'b1 : (fire ? 1'b0 : in_valid_reg);
    assign out_valid_next = fire ? 1'b1 : (out_stall ? out_valid_reg : 1'b0);

    spr_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_wr_en),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    spr_core u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .fire           (fire),
        .opcode         (opcode_reg),
        .position_value (pos_value_reg),
        .cfg            (cfg),
        .result         (core_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            opcode_reg    <= opcode;
            pos_value_reg <= position_value[POSITION_BITS-1:0];
        end
        if (fire)
        begin
            result_reg <= core_result;
        end
    end

    assign out_valid      = out_valid_reg;
    assign step_level     = result_reg.step_level;
    assign output_enabled = result_reg.output_enabled;
    assign position_now   = 32'($signed(result_reg.position));
    assign period_now     = result_reg.period;
    assign run_finished   = result_reg.run_finished;

endmodule

`default_nettype wire

### design/spr_cfg.sv
// ----------------------------------------------------------------------------
// spr_cfg
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module spr_cfg
    import spr_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     wr_en,
    input  wire logic [CFG_IDX_BITS-1:0]  wr_index,
    input  wire logic [CFG_DATA_BITS-1:0] wr_data,
    output cfg_t                          cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                REG_START_PERIOD:   cfg_next.start_period   = wr_data[PERIOD_BITS-1:0];
                REG_TARGET_PERIOD:  cfg_next.target_period  = wr_data[PERIOD_BITS-1:0];
                REG_FINAL_POSITION: cfg_next.final_position = wr_data[POSITION_BITS-1:0];
                REG_REVERSE:        cfg_next.reverse        = wr_data[0];
                REG_RAMP_ENABLE:    cfg_next.ramp_enable    = wr_data[0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_period   <= 8'd255;
            cfg_reg.target_period  <= 8'd255;
            cfg_reg.final_position <= '0;
            cfg_reg.reverse        <= 1'b0;
            cfg_reg.ramp_enable    <= 1'b1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

### design/spr_core.sv
// ----------------------------------------------------------------------------
// spr_core
// Generator state and single-pass update for one request.
// ----------------------------------------------------------------------------
`default_nettype none

module spr_core
    import spr_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     fire,
    input  wire logic [1:0]               opcode,
    input  wire logic [POSITION_BITS-1:0] position_value,
    input  wire cfg_t                     cfg,
    output result_t                       result
);

    logic [PERIOD_BITS-1:0]   tick_count_reg, tick_count_next;
    logic [PERIOD_BITS-1:0]   period_reg, period_next;
    logic                     pin_level_reg, pin_level_next;
    logic                     running_reg, running_next;
    logic                     first_half_reg, first_half_next;
    logic [POSITION_BITS-1:0] position_reg, position_next;
    logic [POSITION_BITS-1:0] accel_end_reg, accel_end_next;
    logic [POSITION_BITS-1:0] decel_begin_reg, decel_begin_next;
    logic                     finished;

    logic [PERIOD_BITS:0]     diff;
    logic [PERIOD_BITS:0]     diff_dir;
    logic [POSITION_BITS-1:0] delta;
    logic [POSITION_BITS-1:0] pos_step;
    logic                     lt_accel, gt_accel, lt_decel, gt_decel;
    logic                     before_accel, before_decel;

    // signed distance start - target, negated when counting down
    assign diff     = {1'b0, cfg.start_period} - {1'b0, cfg.target_period};
    assign diff_dir = cfg.reverse ? (~diff + 1'b1) : diff;
    assign delta    = POSITION_BITS'($signed(diff_dir));

    assign pos_step = cfg.reverse ? (position_reg - 1'b1) : (position_reg + 1'b1);

    assign lt_accel = $signed(pos_step) < $signed(accel_end_reg);
    assign gt_accel = $signed(accel_end_reg) < $signed(pos_step);
    assign lt_decel = $signed(pos_step) < $signed(decel_begin_reg);
    assign gt_decel = $signed(decel_begin_reg) < $signed(pos_step);
    assign before_accel = cfg.reverse ? gt_accel : lt_accel;
    assign before_decel = cfg.reverse ? gt_decel : lt_decel;

    always_comb
    begin
        tick_count_next  = tick_count_reg;
        period_next      = period_reg;
        pin_level_next   = pin_level_reg;
        running_next     = running_reg;
        first_half_next  = first_half_reg;
        position_next    = position_reg;
        accel_end_next   = accel_end_reg;
        decel_begin_next = decel_begin_reg;
        finished         = 1'b0;

        case (opcode_t'(opcode))
            OP_TICK:
            begin
                if (running_reg)
                begin
                    if (tick_count_reg >= period_reg)
                    begin
                        tick_count_next = '0;
                        pin_level_next  = ~pin_level_reg;
                        if (first_half_reg)
                        begin
                            position_next = pos_step;
                            if (pos_step == cfg.final_position)
                            begin
                                running_next    = 1'b0;
                                period_next     = IDLE_PERIOD;
                                first_half_next = 1'b1;
                                finished        = 1'b1;
                            end
                            else
                            begin
                                first_half_next = 1'b0;
                                if (cfg.ramp_enable)
                                begin
                                    if (before_accel)
                                    begin
                                        if (period_reg > cfg.target_period)
                                            period_next = period_reg - 1'b1;
                                    end
                                    else if (before_decel)
                                        period_next = cfg.target_period;
                                    else if (period_reg < cfg.start_period)
                                        period_next = period_reg + 1'b1;
                                end
                            end
                        end
                        else
                        begin
                            first_half_next = 1'b1;
                        end
                    end
                    else
                    begin
                        tick_count_next = tick_count_reg + 1'b1;
                    end
                end
            end
            OP_START:
            begin
                if (cfg.ramp_enable)
                begin
                    accel_end_next   = position_reg + delta;
                    decel_begin_next = cfg.final_position - delta;
                end
                tick_count_next = '0;
                period_next     = cfg.start_period;
                running_next    = 1'b1;
            end
            OP_STOP:
            begin
                running_next    = 1'b0;
                tick_count_next = '0;
                period_next     = IDLE_PERIOD;
            end
            OP_LOAD:
            begin
                position_next = position_value;
            end
            default:
            begin
                position_next = position_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_count_reg  <= '0;
            period_reg      <= IDLE_PERIOD;
            pin_level_reg   <= 1'b0;
            running_reg     <= 1'b0;
            first_half_reg  <= 1'b1;
            position_reg    <= '0;
            accel_end_reg   <= '0;
            decel_begin_reg <= '0;
        end
        else if (fire)
        begin
            tick_count_reg  <= tick_count_next;
            period_reg      <= period_next;
            pin_level_reg   <= pin_level_next;
            running_reg     <= running_next;
            first_half_reg  <= first_half_next;
            position_reg    <= position_next;
            accel_end_reg   <= accel_end_next;
            decel_begin_reg <= decel_begin_next;
        end
    end

    always_comb
    begin
        result.step_level     = pin_level_next;
        result.output_enabled = running_next;
        result.position       = position_next;
        result.period         = period_next;
        result.run_finished   = finished;
    end

endmodule

`default_nettype wire
